// ===== rtl/core/rd64_pkg.sv =====
// Shared types for the pipelined 64-bit restoring divider.
// Holds the operation codes and the control word that travels down the cell chain.
// No dependencies.
package rd64_pkg;

   typedef enum logic [1:0] {
      OP_UDIV = 2'd0,
      OP_UREM = 2'd1,
      OP_SDIV = 2'd2,
      OP_SREM = 2'd3
   } rd_op_type;

   // Control word carried alongside the data of every pipeline stage.
   typedef struct packed {
      logic      valid;
      rd_op_type op;
      logic      q_neg;
      logic      r_neg;
      logic      dzero;
   } rd_ctl_type;

endpackage

// ===== rtl/core/rd64_prep.sv =====
// Input stage of the divider: forms operand magnitudes and sign flags.
// Registers them for the first divide cell. Depends on rd64_pkg.
module rd64_prep #(
   parameter int DATA_WIDTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      req_valid,
   input  logic [1:0]                req_type,
   input  logic [63:0]               req_dividend,
   input  logic [63:0]               req_divisor,
   output rd64_pkg::rd_ctl_type      ctl_out,
   output logic [DATA_WIDTH-1:0]     n_out,
   output logic [DATA_WIDTH-1:0]     d_out
);
   import rd64_pkg::*;

   logic [DATA_WIDTH-1:0] n_raw;
   logic [DATA_WIDTH-1:0] d_raw;
   logic                  is_signed;
   logic                  n_neg;
   logic                  d_neg;
   rd_op_type             op;
   rd_ctl_type            ctl_ff;
   rd_ctl_type            ctl_in;
   logic [DATA_WIDTH-1:0] n_ff;
   logic [DATA_WIDTH-1:0] n_in;
   logic [DATA_WIDTH-1:0] d_ff;
   logic [DATA_WIDTH-1:0] d_in;

   always_comb begin
      op        = rd_op_type'(req_type);
      n_raw     = req_dividend[DATA_WIDTH-1:0];
      d_raw     = req_divisor[DATA_WIDTH-1:0];
      is_signed = (op == OP_SDIV) || (op == OP_SREM);
      n_neg     = is_signed && n_raw[DATA_WIDTH-1];
      d_neg     = is_signed && d_raw[DATA_WIDTH-1];
      n_in      = n_neg ? (~n_raw + 1'b1) : n_raw;
      d_in      = d_neg ? (~d_raw + 1'b1) : d_raw;
      ctl_in.valid = req_valid;
      ctl_in.op    = op;
      ctl_in.q_neg = (op == OP_SDIV) && (n_neg != d_neg);
      ctl_in.r_neg = (op == OP_SREM) && n_neg;
      ctl_in.dzero = (d_raw == '0);
   end

   // Only the valid flag needs a reset; the payload is don't-care while idle.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl_ff.valid <= ctl_in.valid;
      end
      if (advance) begin
         ctl_ff.op    <= ctl_in.op;
         ctl_ff.q_neg <= ctl_in.q_neg;
         ctl_ff.r_neg <= ctl_in.r_neg;
         ctl_ff.dzero <= ctl_in.dzero;
         n_ff         <= n_in;
         d_ff         <= d_in;
      end
   end

   assign ctl_out = ctl_ff;
   assign n_out   = n_ff;
   assign d_out   = d_ff;

endmodule

// ===== rtl/core/rd64_cell.sv =====
// One restoring divide step, registered. A chain of these forms the divider core.
// Depends on rd64_pkg.
module rd64_cell #(
   parameter int DATA_WIDTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  rd64_pkg::rd_ctl_type      ctl_in_s,
   input  logic [DATA_WIDTH-1:0]     rem_in_s,
   input  logic [DATA_WIDTH-1:0]     nq_in_s,
   input  logic [DATA_WIDTH-1:0]     d_in_s,
   output rd64_pkg::rd_ctl_type      ctl_out,
   output logic [DATA_WIDTH-1:0]     rem_out,
   output logic [DATA_WIDTH-1:0]     nq_out,
   output logic [DATA_WIDTH-1:0]     d_out
);
   import rd64_pkg::*;

   logic [DATA_WIDTH:0]   shifted;
   logic [DATA_WIDTH:0]   diff;
   logic                  ge;
   rd_ctl_type            ctl_ff;
   logic [DATA_WIDTH-1:0] rem_ff;
   logic [DATA_WIDTH-1:0] rem_in;
   logic [DATA_WIDTH-1:0] nq_ff;
   logic [DATA_WIDTH-1:0] nq_in;
   logic [DATA_WIDTH-1:0] d_ff;

   // The nq word holds the dividend bits still to be brought down; quotient
   // bits enter at the bottom, so after the last cell it holds the quotient.
   always_comb begin
      shifted = {rem_in_s, nq_in_s[DATA_WIDTH-1]};
      diff    = shifted - {1'b0, d_in_s};
      ge      = (shifted >= {1'b0, d_in_s});
      rem_in  = ge ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
      nq_in   = {nq_in_s[DATA_WIDTH-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl_ff.valid <= ctl_in_s.valid;
      end
      if (advance) begin
         ctl_ff.op    <= ctl_in_s.op;
         ctl_ff.q_neg <= ctl_in_s.q_neg;
         ctl_ff.r_neg <= ctl_in_s.r_neg;
         ctl_ff.dzero <= ctl_in_s.dzero;
         rem_ff       <= rem_in;
         nq_ff        <= nq_in;
         d_ff         <= d_in_s;
      end
   end

   assign ctl_out = ctl_ff;
   assign rem_out = rem_ff;
   assign nq_out  = nq_ff;
   assign d_out   = d_ff;

endmodule

// ===== rtl/core/rd64_post.sv =====
// Output stage: applies signs, selects quotient or remainder, holds the response.
// Depends on rd64_pkg.
module rd64_post #(
   parameter int DATA_WIDTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rd64_pkg::rd_ctl_type      ctl_in_s,
   input  logic [DATA_WIDTH-1:0]     q_in_s,
   input  logic [DATA_WIDTH-1:0]     r_in_s,
   input  logic                      rsp_stall,
   output logic                      out_free,
   output logic                      rsp_valid,
   output logic [63:0]               rsp_result
);
   import rd64_pkg::*;

   logic [DATA_WIDTH-1:0] res;
   logic                  valid_ff;
   logic [63:0]           result_ff;
   logic [63:0]           result_in;

   always_comb begin
      case (ctl_in_s.op)
         OP_UDIV: res = q_in_s;
         OP_UREM: res = r_in_s;
         OP_SDIV: res = ctl_in_s.q_neg ? (~q_in_s + 1'b1) : q_in_s;
         OP_SREM: res = ctl_in_s.r_neg ? (~r_in_s + 1'b1) : r_in_s;
         default: res = q_in_s;
      endcase
      if (ctl_in_s.dzero) begin
         res = '0;
      end
      result_in = 64'(res);
   end

   assign out_free = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_free) begin
         valid_ff <= ctl_in_s.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

// ===== rtl/core/restoring_divider_64.sv =====
// Pipelined integer divider: unsigned or signed quotient or remainder of two
// DATA_WIDTH-bit operands, one request accepted per cycle while req_stall is low.
// A request passes an operand stage, DATA_WIDTH divide cells (one quotient bit
// each) and an output register, where rsp_valid rises; the response is taken
// at an edge when the response side does not stall. A zero divisor gives 0;
// the most negative value over minus one wraps to itself.
// Depends on rd64_pkg, rd64_prep, rd64_cell and rd64_post.
module restoring_divider_64 #(
   parameter int DATA_WIDTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [63:0] req_dividend,
   input  logic [63:0] req_divisor,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result
);
   import rd64_pkg::*;

   rd_ctl_type            ctl_s [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] rem_s [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] nq_s  [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] d_s   [0:DATA_WIDTH];
   logic                  out_free;
   logic                  advance;

   // The chain moves whenever the output register can take the last cell's
   // request, or the last cell holds nothing.
   assign advance   = out_free || !ctl_s[DATA_WIDTH].valid;
   assign req_stall = !advance;
   assign rem_s[0]  = '0;

   rd64_prep #(.DATA_WIDTH(DATA_WIDTH)) u_prep (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .req_valid    (req_valid),
      .req_type     (req_type),
      .req_dividend (req_dividend),
      .req_divisor  (req_divisor),
      .ctl_out      (ctl_s[0]),
      .n_out        (nq_s[0]),
      .d_out        (d_s[0])
   );

   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
      rd64_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .ctl_in_s (ctl_s[i]),
         .rem_in_s (rem_s[i]),
         .nq_in_s  (nq_s[i]),
         .d_in_s   (d_s[i]),
         .ctl_out  (ctl_s[i+1]),
         .rem_out  (rem_s[i+1]),
         .nq_out   (nq_s[i+1]),
         .d_out    (d_s[i+1])
      );
   end

   rd64_post #(.DATA_WIDTH(DATA_WIDTH)) u_post (
      .clock      (clock),
      .reset      (reset),
      .ctl_in_s   (ctl_s[DATA_WIDTH]),
      .q_in_s     (nq_s[DATA_WIDTH]),
      .r_in_s     (rem_s[DATA_WIDTH]),
      .rsp_stall  (rsp_stall),
      .out_free   (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result)
   );

   // A held response with a finished request behind it must freeze the chain.
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall && ctl_s[DATA_WIDTH].valid) |-> req_stall)
      else $error("divider chain advanced over a held response");

   // The final partial remainder of a valid request with a nonzero divisor is below the divisor.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (ctl_s[DATA_WIDTH].valid && !ctl_s[DATA_WIDTH].dzero)
         |-> (rem_s[DATA_WIDTH] < d_s[DATA_WIDTH]))
      else $error("divider remainder not below divisor");

   // A zero divisor yields a zero response.
   a_dzero: assert property (@(posedge clock) disable iff (reset)
      (out_free && ctl_s[DATA_WIDTH].valid && ctl_s[DATA_WIDTH].dzero)
         |=> (rsp_result == 64'd0))
      else $error("divider zero divisor gave nonzero response");

   // Response bits above the data width stay clear.
   a_upper: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_result >> DATA_WIDTH) == 64'd0))
      else $error("divider response has bits above the data width");

endmodule
